// File: rtl/core/dwsp_pkg.sv
`default_nettype none

package dwsp_pkg;

  // Field widths
  localparam int SPEED_BITS     = 16;
  localparam int GAIN_BITS      = 16;
  localparam int DRIVE_BITS     = 32;
  localparam int INTEG_BITS     = 32;
  localparam int GAIN_FRAC_BITS = 12;
  localparam int CFG_IDX_BITS   = 2;

  // Register defaults (unsigned Q4.12)
  localparam logic [GAIN_BITS-1:0] RESET_PROP  = 16'd20480;
  localparam logic [GAIN_BITS-1:0] RESET_INTEG = 16'd410;
  localparam logic [GAIN_BITS-1:0] RESET_DERIV = 16'd0;

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_GAIN_PROP  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_GAIN_INTEG = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_GAIN_DERIV = 2'd2;

  typedef struct packed {
    logic signed [SPEED_BITS-1:0] target_left;
    logic signed [SPEED_BITS-1:0] target_right;
    logic signed [SPEED_BITS-1:0] measured_left;
    logic signed [SPEED_BITS-1:0] measured_right;
  } in_item_t;

  typedef struct packed {
    logic signed [DRIVE_BITS-1:0] drive_left;
    logic signed [DRIVE_BITS-1:0] drive_right;
  } out_item_t;

  typedef struct packed {
    logic [GAIN_BITS-1:0] prop;
    logic [GAIN_BITS-1:0] integ;
    logic [GAIN_BITS-1:0] deriv;
  } gains_t;

endpackage

`default_nettype wire

// File: rtl/core/dwsp_wheel.sv
`default_nettype none

module dwsp_wheel #(
  parameter int FRAC_BITS = dwsp_pkg::GAIN_FRAC_BITS,
  parameter bit NEGATE    = 1'b0
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    en,
  input  wire dwsp_pkg::gains_t                        gains,
  input  wire logic signed [dwsp_pkg::SPEED_BITS-1:0]  target,
  input  wire logic signed [dwsp_pkg::SPEED_BITS-1:0]  measured,
  output logic signed [dwsp_pkg::DRIVE_BITS-1:0]       drive
);

  localparam int EW    = dwsp_pkg::SPEED_BITS + 1;
  localparam int GW    = dwsp_pkg::GAIN_BITS + 1;
  localparam int IW    = dwsp_pkg::INTEG_BITS;
  localparam int DW    = dwsp_pkg::DRIVE_BITS;
  localparam int PPW   = EW + GW;
  localparam int IPW   = IW + GW;
  localparam int SUM_W = IPW + 2;

  localparam logic [SUM_W-1:0] BIAS = (SUM_W'(1) << FRAC_BITS) - SUM_W'(1);
  localparam logic [IW-1:0] IMAX = {1'b0, {(IW-1){1'b1}}};
  localparam logic [IW-1:0] IMIN = {1'b1, {(IW-1){1'b0}}};
  localparam logic [DW-1:0] DMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] DMIN = {1'b1, {(DW-1){1'b0}}};

  logic signed [IW-1:0]                   integ;
  logic signed [IW-1:0]                   integ_next;
  logic signed [dwsp_pkg::SPEED_BITS-1:0] prev_meas;

  logic signed [EW-1:0]    err;
  logic signed [EW-1:0]    der;
  logic signed [IW:0]      integ_wide;
  logic signed [GW-1:0]    kp_s;
  logic signed [GW-1:0]    ki_s;
  logic signed [GW-1:0]    kd_s;
  logic signed [PPW-1:0]   prod_p;
  logic signed [IPW-1:0]   prod_i;
  logic signed [PPW-1:0]   prod_d;
  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] biased;
  logic signed [SUM_W-1:0] shifted;
  logic signed [SUM_W-1:0] signed_val;
  logic                    all_ones;
  logic                    all_zeros;

  // Error and derivative on measurement
  assign err = EW'(target) - EW'(measured);
  assign der = EW'(prev_meas) - EW'(measured);

  // Accumulate and clamp the integral
  assign integ_wide = (IW+1)'(integ) + (IW+1)'(err);
  always_comb begin
    if (integ_wide[IW] != integ_wide[IW-1]) begin
      integ_next = integ_wide[IW] ? $signed(IMIN) : $signed(IMAX);
    end else begin
      integ_next = integ_wide[IW-1:0];
    end
  end

  // Gain products, gains zero extended to signed
  assign kp_s   = $signed({1'b0, gains.prop});
  assign ki_s   = $signed({1'b0, gains.integ});
  assign kd_s   = $signed({1'b0, gains.deriv});
  assign prod_p = PPW'(err) * PPW'(kp_s);
  assign prod_i = IPW'(integ_next) * IPW'(ki_s);
  assign prod_d = PPW'(der) * PPW'(kd_s);
  assign sum    = SUM_W'(prod_p) + SUM_W'(prod_i) + SUM_W'(prod_d);

  // Drop fraction bits, truncating toward zero
  assign biased  = sum[SUM_W-1] ? (sum + $signed(BIAS)) : sum;
  assign shifted = biased >>> FRAC_BITS;

  // Negate when asked, then clamp to the drive range
  assign signed_val = NEGATE ? -shifted : shifted;
  assign all_ones   = &signed_val[SUM_W-1:DW-1];
  assign all_zeros  = ~|signed_val[SUM_W-1:DW-1];
  always_comb begin
    if (all_ones || all_zeros) begin
      drive = signed_val[DW-1:0];
    end else begin
      drive = signed_val[SUM_W-1] ? $signed(DMIN) : $signed(DMAX);
    end
  end

  // Advance per-wheel state on each transfer into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      integ     <= '0;
      prev_meas <= '0;
    end else if (en) begin
      integ     <= integ_next;
      prev_meas <= measured;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/dual_wheel_speed_pid_unit.sv
// Two-wheel speed PID, derivative taken on the measurement.
// Stages: input register, then result register. Throughput: one item per cycle
// unless out_stall holds it; the single-pass datapath of each wheel sets that rate.
// Reset (synchronous, active high): clears both stage valids, integrals and previous
// measurements, and loads the gains with their defaults.
`default_nettype none

module dual_wheel_speed_pid_unit #(
  parameter int GAIN_FRAC_BITS = dwsp_pkg::GAIN_FRAC_BITS
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire dwsp_pkg::in_item_t                    in_data,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output dwsp_pkg::out_item_t                        out_data,
  input  wire logic                                  cfg_we,
  input  wire logic [dwsp_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  wire logic [dwsp_pkg::GAIN_BITS-1:0]        cfg_data
);

  dwsp_pkg::gains_t    gains;
  dwsp_pkg::in_item_t  in_reg;
  logic                in_v;
  logic                advance;
  logic                in_take;
  logic signed [dwsp_pkg::DRIVE_BITS-1:0] drive_l;
  logic signed [dwsp_pkg::DRIVE_BITS-1:0] drive_r;

  // Pipeline handshake
  assign advance  = in_v && (!out_valid || !out_stall);
  assign in_stall = in_v && !advance;
  assign in_take  = in_valid && !in_stall;

  // Gain registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gains.prop  <= dwsp_pkg::RESET_PROP;
      gains.integ <= dwsp_pkg::RESET_INTEG;
      gains.deriv <= dwsp_pkg::RESET_DERIV;
    end else if (cfg_we) begin
      case (cfg_index)
        dwsp_pkg::CFG_GAIN_PROP:  gains.prop  <= cfg_data;
        dwsp_pkg::CFG_GAIN_INTEG: gains.integ <= cfg_data;
        dwsp_pkg::CFG_GAIN_DERIV: gains.deriv <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (in_take) begin
      in_v <= 1'b1;
    end else if (advance) begin
      in_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_reg <= in_data;
    end
  end

  // Per-wheel datapaths
  dwsp_wheel #(
    .FRAC_BITS (GAIN_FRAC_BITS),
    .NEGATE    (1'b0)
  ) u_left (
    .clk      (clk),
    .rst      (rst),
    .en       (advance),
    .gains    (gains),
    .target   (in_reg.target_left),
    .measured (in_reg.measured_left),
    .drive    (drive_l)
  );

  dwsp_wheel #(
    .FRAC_BITS (GAIN_FRAC_BITS),
    .NEGATE    (1'b1)
  ) u_right (
    .clk      (clk),
    .rst      (rst),
    .en       (advance),
    .gains    (gains),
    .target   (in_reg.target_right),
    .measured (in_reg.measured_right),
    .drive    (drive_r)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data.drive_left  <= drive_l;
      out_data.drive_right <= drive_r;
    end
  end

`ifndef NO_ASSERTIONS
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (in_v && out_valid && out_stall))
    else $error("input stalled while the pipeline can move");

  a_advance_fills_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("result register empty after an advance");

  a_reset_empties: assert property (@(posedge clk)
    $past(rst) |-> (!in_v && !out_valid))
    else $error("pipeline holds an item after reset");

  a_reset_gains: assert property (@(posedge clk)
    $past(rst) |-> (gains.prop == dwsp_pkg::RESET_PROP &&
                    gains.integ == dwsp_pkg::RESET_INTEG &&
                    gains.deriv == dwsp_pkg::RESET_DERIV))
    else $error("gains not at defaults after reset");
`endif

endmodule

`default_nettype wire
